>>> sv/radar_measurement_jacobian_unit_defines.svh
// Assertion macros shared by the radar measurement Jacobian RTL.
// Define ASSERT_OFF to compile all assertions out.
`ifndef RADAR_MEASUREMENT_JACOBIAN_UNIT_DEFINES_SVH
`define RADAR_MEASUREMENT_JACOBIAN_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RMJ_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define RMJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RMJ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RMJ_ASSERT(lbl, cond)
`define RMJ_ASSERT_IMP(lbl, ante, cons)
`define RMJ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/rmj_pkg.sv
// Types, constants and saturation helpers for the radar measurement Jacobian.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmj_pkg;
  localparam int QW = 33;
  localparam int CFG_W = 40;
  localparam logic [CFG_W-1:0] CFG_RESET = 40'd429497;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } rmj_in_t;

  typedef struct packed {
    logic signed [31:0] drange_dx;
    logic signed [31:0] drange_dy;
    logic signed [31:0] dbearing_dx;
    logic signed [31:0] dbearing_dy;
    logic signed [31:0] drate_dx;
    logic signed [31:0] drate_dy;
    logic               near_zero_error;
  } rmj_out_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] ucap(input logic [QW-1:0] q, input logic ovf);
    return (ovf || q > 33'h080000000) ? 32'h80000000 : q[31:0];
  endfunction

  function automatic logic [31:0] sat_entry(input logic [QW-1:0] q, input logic ovf,
                                            input logic neg);
    logic [QW-1:0] cap;
    logic [QW-1:0] m;
    cap = neg ? 33'h080000000 : 33'h07FFFFFFF;
    m = (ovf || q > cap) ? cap : q;
    return neg ? (32'd0 - m[31:0]) : m[31:0];
  endfunction
endpackage
`default_nettype wire

>>> sv/rmj_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Depends on nothing; carries a sideband word alongside the operand.
`timescale 1ns / 1ps
`default_nettype none
module rmj_isqrt #(
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [63:0]       val_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [31:0]            root_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int NS = 32;

  logic              vld_r  [0:NS];
  logic [63:0]       n_r    [0:NS];
  logic [63:0]       res_r  [0:NS];
  logic [SIDE_W-1:0] side_r [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= val_i;
      res_r[0]  <= '0;
      side_r[0] <= side_i;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (2 * (NS - 1 - i));
    logic [63:0] sum;
    logic        ge;
    logic [63:0] n_nxt;
    logic [63:0] res_nxt;
    assign sum     = res_r[i] + BIT;
    assign ge      = n_r[i] >= sum;
    assign n_nxt   = ge ? (n_r[i] - sum) : n_r[i];
    assign res_nxt = ge ? ((res_r[i] >> 1) + BIT) : (res_r[i] >> 1);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1]    <= n_nxt;
        res_r[i+1]  <= res_nxt;
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign vld_o  = vld_r[NS];
  assign root_o = res_r[NS][31:0];
  assign side_o = side_r[NS];
endmodule
`default_nettype wire

>>> sv/rmj_div.sv
// Pipelined restoring divider giving a 33-bit quotient and an overflow flag.
// Depends on rmj_pkg; carries a sideband word alongside the operands.
`timescale 1ns / 1ps
`default_nettype none
module rmj_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [rmj_pkg::QW-1:0] q_o,
  output logic                   ovf_o,
  output logic [SIDE_W-1:0]      side_o
);
  import rmj_pkg::*;

  localparam int HW = NUM_W - QW;
  localparam int CW = (HW > DEN_W) ? HW : DEN_W;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  logic              vld_r  [0:QW];
  logic [DEN_W-1:0]  rem_r  [0:QW];
  logic [QW-1:0]     low_r  [0:QW];
  logic [QW-1:0]     q_r    [0:QW];
  logic [DEN_W-1:0]  den_r  [0:QW];
  logic              ovf_r  [0:QW];
  logic [SIDE_W-1:0] side_r [0:QW];

  assign hi_ext  = CW'(num_i[NUM_W-1:QW]);
  assign den_ext = CW'(den_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= hi_ext[DEN_W-1:0];
      low_r[0]  <= num_i[QW-1:0];
      q_r[0]    <= '0;
      den_r[0]  <= den_i;
      ovf_r[0]  <= hi_ext >= den_ext;
      side_r[0] <= side_i;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    assign sh      = {rem_r[j], low_r[j][QW-1]};
    assign diff    = sh - {1'b0, den_r[j]};
    assign ge      = sh >= {1'b0, den_r[j]};
    assign rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= rem_nxt;
        low_r[j+1]  <= {low_r[j][QW-2:0], 1'b0};
        q_r[j+1]    <= {q_r[j][QW-2:0], ge};
        den_r[j+1]  <= den_r[j];
        ovf_r[j+1]  <= ovf_r[j];
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign vld_o  = vld_r[QW];
  assign q_o    = q_r[QW];
  assign ovf_o  = ovf_r[QW];
  assign side_o = side_r[QW];
endmodule
`default_nettype wire

>>> sv/radar_measurement_jacobian_unit.sv
// Top level of the radar measurement Jacobian pipeline.
// Depends on rmj_pkg, rmj_isqrt, rmj_div and the assertion macro header.
//
// One transaction on the in_ channel carries a track state (position and
// velocity, signed fixed point with FRAC_BITS fraction bits). One transaction
// on the out_ channel returns the six Jacobian entries and near_zero_error.
// The cfg_ channel writes the 40-bit squared-range threshold (Q8.32); it is
// always ready and should only be written while no transaction is in flight.
// From input acceptance to out_valid a transaction passes three front-end
// stages, 33 square-root stages, 34 divider stages for the range terms, three
// product stages, 34 divider stages for the range-rate terms and the output
// register. Throughput is one transaction per cycle unless the receiver stalls.
// Reset clears every valid bit and loads the threshold with its default.
// When the receiver stalls, the whole pipeline holds and in_ready drops in the
// same cycle, so no transaction is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "radar_measurement_jacobian_unit_defines.svh"
module radar_measurement_jacobian_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire rmj_pkg::rmj_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output rmj_pkg::rmj_out_t              out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [rmj_pkg::CFG_W-1:0] cfg_data
);
  import rmj_pkg::*;

  localparam int F2  = 2 * FRAC_BITS;
  localparam int SH  = (F2 <= 32) ? (32 - F2) : (F2 - 32);
  localparam int SQ_SIDE_W = 196;
  localparam int D1_SIDE_W = 132;
  localparam int D2_SIDE_W = 131;

  logic en;
  logic [CFG_W-1:0] thr_r;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= CFG_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // Stage 1: magnitudes and signs.
  logic        s1_vld_r;
  logic [31:0] s1_px_r, s1_py_r, s1_vx_r, s1_vy_r;
  logic        s1_npx_r, s1_npy_r, s1_nvx_r, s1_nvy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px_r  <= mag32(in_data.pos_x);
      s1_py_r  <= mag32(in_data.pos_y);
      s1_vx_r  <= mag32(in_data.vel_x);
      s1_vy_r  <= mag32(in_data.vel_y);
      s1_npx_r <= in_data.pos_x[31];
      s1_npy_r <= in_data.pos_y[31];
      s1_nvx_r <= in_data.vel_x[31];
      s1_nvy_r <= in_data.vel_y[31];
    end
  end

  // Stage 2: squares and cross products.
  logic        s2_vld_r;
  logic [63:0] s2_pxx_r, s2_pyy_r, s2_a_r, s2_b_r;
  logic        s2_sa_r, s2_sb_r, s2_npx_r, s2_npy_r;
  logic [31:0] s2_px_r, s2_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pxx_r <= 64'(s1_px_r) * 64'(s1_px_r);
      s2_pyy_r <= 64'(s1_py_r) * 64'(s1_py_r);
      s2_a_r   <= 64'(s1_vx_r) * 64'(s1_py_r);
      s2_b_r   <= 64'(s1_vy_r) * 64'(s1_px_r);
      s2_sa_r  <= s1_nvx_r ^ s1_npy_r;
      s2_sb_r  <= s1_nvy_r ^ s1_npx_r;
      s2_npx_r <= s1_npx_r;
      s2_npy_r <= s1_npy_r;
      s2_px_r  <= s1_px_r;
      s2_py_r  <= s1_py_r;
    end
  end

  // Stage 3: squared range, threshold test and signed cross term.
  logic        s3_vld_r;
  logic [63:0] s3_r2_r, s3_cm_r;
  logic        s3_cneg_r, s3_flag_r, s3_npx_r, s3_npy_r;
  logic [31:0] s3_px_r, s3_py_r;
  logic [63:0] r2_nxt, thr64, thr_cmp, cm_nxt;
  logic        cneg_nxt, flag_nxt;

  assign r2_nxt  = s2_pxx_r + s2_pyy_r;
  assign thr64   = 64'(thr_r);
  assign thr_cmp = (F2 <= 32) ? ((thr64 + ((64'd1 << SH) - 64'd1)) >> SH) : (thr64 << SH);
  assign flag_nxt = (r2_nxt < thr_cmp) || (r2_nxt == 64'd0);

  always_comb begin
    if (s2_sa_r != s2_sb_r) begin
      cm_nxt   = s2_a_r + s2_b_r;
      cneg_nxt = s2_sa_r;
    end else if (s2_a_r >= s2_b_r) begin
      cm_nxt   = s2_a_r - s2_b_r;
      cneg_nxt = s2_sa_r;
    end else begin
      cm_nxt   = s2_b_r - s2_a_r;
      cneg_nxt = !s2_sa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r2_r   <= r2_nxt;
      s3_cm_r   <= cm_nxt;
      s3_cneg_r <= cneg_nxt;
      s3_flag_r <= flag_nxt;
      s3_npx_r  <= s2_npx_r;
      s3_npy_r  <= s2_npy_r;
      s3_px_r   <= s2_px_r;
      s3_py_r   <= s2_py_r;
    end
  end

  // Square root of the squared range.
  logic                 sq_vld;
  logic [31:0]          sq_r;
  logic [SQ_SIDE_W-1:0] sq_side;
  logic                 sq_flag, sq_npx, sq_npy, sq_cneg;
  logic [63:0]          sq_cm, sq_r2;
  logic [31:0]          sq_px, sq_py;

  rmj_isqrt #(.SIDE_W(SQ_SIDE_W)) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s3_vld_r),
    .val_i  (s3_r2_r),
    .side_i ({s3_flag_r, s3_npx_r, s3_npy_r, s3_cneg_r, s3_cm_r, s3_px_r, s3_py_r,
              s3_r2_r}),
    .vld_o  (sq_vld),
    .root_o (sq_r),
    .side_o (sq_side)
  );

  assign {sq_flag, sq_npx, sq_npy, sq_cneg, sq_cm, sq_px, sq_py, sq_r2} = sq_side;

  // Range and bearing divisions.
  logic                 d1_vld;
  logic [D1_SIDE_W-1:0] d1_side;
  logic [QW-1:0]        q_ux, q_uy, q_bx, q_by;
  logic                 o_ux, o_uy, o_bx, o_by;
  logic                 d1_flag, d1_npx, d1_npy, d1_cneg;
  logic [63:0]          d1_cm, d1_r2;

  rmj_div #(.NUM_W(32 + FRAC_BITS), .DEN_W(32), .SIDE_W(D1_SIDE_W)) u_div_ux (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (sq_vld),
    .num_i ({sq_px, {FRAC_BITS{1'b0}}}), .den_i (sq_r),
    .side_i ({sq_flag, sq_npx, sq_npy, sq_cneg, sq_cm, sq_r2}),
    .vld_o (d1_vld), .q_o (q_ux), .ovf_o (o_ux), .side_o (d1_side)
  );

  rmj_div #(.NUM_W(32 + FRAC_BITS), .DEN_W(32), .SIDE_W(1)) u_div_uy (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (sq_vld),
    .num_i ({sq_py, {FRAC_BITS{1'b0}}}), .den_i (sq_r), .side_i (1'b0),
    .vld_o (), .q_o (q_uy), .ovf_o (o_uy), .side_o ()
  );

  rmj_div #(.NUM_W(32 + F2), .DEN_W(64), .SIDE_W(1)) u_div_bx (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (sq_vld),
    .num_i ({sq_py, {F2{1'b0}}}), .den_i (sq_r2), .side_i (1'b0),
    .vld_o (), .q_o (q_bx), .ovf_o (o_bx), .side_o ()
  );

  rmj_div #(.NUM_W(32 + F2), .DEN_W(64), .SIDE_W(1)) u_div_by (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (sq_vld),
    .num_i ({sq_px, {F2{1'b0}}}), .den_i (sq_r2), .side_i (1'b0),
    .vld_o (), .q_o (q_by), .ovf_o (o_by), .side_o ()
  );

  assign {d1_flag, d1_npx, d1_npy, d1_cneg, d1_cm, d1_r2} = d1_side;

  // P1: saturate range and bearing entries.
  logic        p1_vld_r;
  logic [31:0] p1_ux_r, p1_uy_r, p1_e0_r, p1_e1_r, p1_e2_r, p1_e3_r;
  logic        p1_flag_r, p1_s4_r, p1_s5_r;
  logic [63:0] p1_cm_r, p1_r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ux_r   <= ucap(q_ux, o_ux);
      p1_uy_r   <= ucap(q_uy, o_uy);
      p1_e0_r   <= sat_entry(q_ux, o_ux, d1_npx);
      p1_e1_r   <= sat_entry(q_uy, o_uy, d1_npy);
      p1_e2_r   <= sat_entry(q_bx, o_bx, !d1_npy);
      p1_e3_r   <= sat_entry(q_by, o_by, d1_npx);
      p1_flag_r <= d1_flag;
      p1_s4_r   <= d1_npy ^ d1_cneg;
      p1_s5_r   <= !(d1_npx ^ d1_cneg);
      p1_cm_r   <= d1_cm;
      p1_r2_r   <= d1_r2;
    end
  end

  // P2: partial products of the cross term with the unit vector.
  logic        p2_vld_r;
  logic [63:0] p2_ylo_r, p2_yhi_r, p2_xlo_r, p2_xhi_r, p2_r2_r;
  logic [31:0] p2_e0_r, p2_e1_r, p2_e2_r, p2_e3_r;
  logic        p2_flag_r, p2_s4_r, p2_s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_ylo_r  <= 64'(p1_cm_r[31:0]) * 64'(p1_uy_r);
      p2_yhi_r  <= 64'(p1_cm_r[63:32]) * 64'(p1_uy_r);
      p2_xlo_r  <= 64'(p1_cm_r[31:0]) * 64'(p1_ux_r);
      p2_xhi_r  <= 64'(p1_cm_r[63:32]) * 64'(p1_ux_r);
      p2_r2_r   <= p1_r2_r;
      p2_e0_r   <= p1_e0_r;
      p2_e1_r   <= p1_e1_r;
      p2_e2_r   <= p1_e2_r;
      p2_e3_r   <= p1_e3_r;
      p2_flag_r <= p1_flag_r;
      p2_s4_r   <= p1_s4_r;
      p2_s5_r   <= p1_s5_r;
    end
  end

  // P3: full 96-bit products.
  logic        p3_vld_r;
  logic [95:0] p3_py_r, p3_px_r;
  logic [63:0] p3_r2_r;
  logic [31:0] p3_e0_r, p3_e1_r, p3_e2_r, p3_e3_r;
  logic        p3_flag_r, p3_s4_r, p3_s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_py_r   <= {p2_yhi_r, 32'd0} + 96'(p2_ylo_r);
      p3_px_r   <= {p2_xhi_r, 32'd0} + 96'(p2_xlo_r);
      p3_r2_r   <= p2_r2_r;
      p3_e0_r   <= p2_e0_r;
      p3_e1_r   <= p2_e1_r;
      p3_e2_r   <= p2_e2_r;
      p3_e3_r   <= p2_e3_r;
      p3_flag_r <= p2_flag_r;
      p3_s4_r   <= p2_s4_r;
      p3_s5_r   <= p2_s5_r;
    end
  end

  // Range-rate divisions.
  logic                 d2_vld;
  logic [D2_SIDE_W-1:0] d2_side;
  logic [QW-1:0]        q_rx, q_ry;
  logic                 o_rx, o_ry;
  logic                 d2_flag, d2_s4, d2_s5;
  logic [31:0]          d2_e0, d2_e1, d2_e2, d2_e3;

  rmj_div #(.NUM_W(96), .DEN_W(64), .SIDE_W(D2_SIDE_W)) u_div_rx (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (p3_vld_r),
    .num_i (p3_py_r), .den_i (p3_r2_r),
    .side_i ({p3_flag_r, p3_s4_r, p3_s5_r, p3_e0_r, p3_e1_r, p3_e2_r, p3_e3_r}),
    .vld_o (d2_vld), .q_o (q_rx), .ovf_o (o_rx), .side_o (d2_side)
  );

  rmj_div #(.NUM_W(96), .DEN_W(64), .SIDE_W(1)) u_div_ry (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (p3_vld_r),
    .num_i (p3_px_r), .den_i (p3_r2_r), .side_i (1'b0),
    .vld_o (), .q_o (q_ry), .ovf_o (o_ry), .side_o ()
  );

  assign {d2_flag, d2_s4, d2_s5, d2_e0, d2_e1, d2_e2, d2_e3} = d2_side;

  // Output register.
  logic     out_vld_r;
  rmj_out_t out_data_r;
  rmj_out_t out_nxt;

  always_comb begin
    if (d2_flag) begin
      out_nxt = '0;
      out_nxt.near_zero_error = 1'b1;
    end else begin
      out_nxt.drange_dx       = d2_e0;
      out_nxt.drange_dy       = d2_e1;
      out_nxt.dbearing_dx     = d2_e2;
      out_nxt.dbearing_dy     = d2_e3;
      out_nxt.drate_dx        = sat_entry(q_rx, o_rx, d2_s4);
      out_nxt.drate_dy        = sat_entry(q_ry, o_ry, d2_s5);
      out_nxt.near_zero_error = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `RMJ_ASSERT_IMP(a_flag_zeroes, out_valid && out_data.near_zero_error, out_data.drange_dx == 32'd0 && out_data.drange_dy == 32'd0 && out_data.drate_dx == 32'd0 && out_data.drate_dy == 32'd0)
  `RMJ_ASSERT_IMP(a_unit_nonzero, out_valid && !out_data.near_zero_error, out_data.drange_dx != 32'd0 || out_data.drange_dy != 32'd0)
  `RMJ_ASSERT_NXT(a_stall_holds, !en, $stable(s3_vld_r) && $stable(s3_r2_r) && $stable(p3_vld_r))
endmodule
`default_nettype wire

>>> sim/radar_measurement_jacobian_unit_tb.sv
// Self-checking testbench for radar_measurement_jacobian_unit: directed and random track states.
// Expected Jacobian entries come from a bit-exact fixed-point predictor kept in this file.
// Depends on rmj_pkg and the radar_measurement_jacobian_unit RTL.
`timescale 1ns / 1ps
module radar_measurement_jacobian_unit_tb;
  import rmj_pkg::*;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000;
  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 130;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rmj_in_t in_data;
  logic out_valid;
  logic out_ready;
  rmj_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  logic [CFG_W-1:0] range_floor;
  rmj_out_t pending_jacobians[$];
  int mismatches;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;

  radar_measurement_jacobian_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] abs_of(input logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
  endfunction

  function automatic logic [31:0] apply_sign(input logic [63:0] m, input logic neg);
    logic [63:0] t;
    t = 64'd0 - m;
    return neg ? t[31:0] : m[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] capped_scale(input logic [63:0] a, input logic [63:0] b,
                                               input logic [63:0] d, input logic [63:0] cap);
    logic [63:0] aq;
    logic [63:0] ar;
    logic [63:0] q;
    logic [63:0] rm;
    aq = a / d;
    ar = a % d;
    q = 0;
    rm = 0;
    for (int i = 63; i >= 0; i--) begin
      if (q > cap) return cap;
      q = q << 1;
      rm = rm << 1;
      if (rm >= d) begin
        rm = rm - d;
        q = q + 1;
      end
      if (b[i]) begin
        if (aq > cap - ((q > cap) ? cap : q)) return cap;
        q = q + aq;
        rm = rm + ar;
        if (rm >= d) begin
          rm = rm - d;
          q = q + 1;
        end
      end
    end
    return (q > cap) ? cap : q;
  endfunction

  function automatic logic [31:0] sat_term(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] d, input logic neg);
    return apply_sign(capped_scale(a, b, d, neg ? NEG_LIMIT : POS_LIMIT), neg);
  endfunction

  function automatic rmj_out_t jacobian_of(input rmj_in_t t, input logic [CFG_W-1:0] thr);
    rmj_out_t o;
    logic [63:0] px, py, vx, vy, r2, r, ux, uy, a, b, cm;
    logic npx, npy, nvx, nvy, sa, sb, cneg;
    px = abs_of(t.pos_x);
    py = abs_of(t.pos_y);
    vx = abs_of(t.vel_x);
    vy = abs_of(t.vel_y);
    npx = t.pos_x[31];
    npy = t.pos_y[31];
    nvx = t.vel_x[31];
    nvy = t.vel_y[31];
    r2 = px * px + py * py;
    o = '0;
    if (r2 < {24'd0, thr} || r2 == 0) begin
      o.near_zero_error = 1'b1;
      return o;
    end
    r = int_sqrt(r2);
    ux = capped_scale(px, 64'd1 << FRAC, r, NEG_LIMIT);
    uy = capped_scale(py, 64'd1 << FRAC, r, NEG_LIMIT);
    o.drange_dx = apply_sign((ux > POS_LIMIT && !npx) ? POS_LIMIT : ux, npx);
    o.drange_dy = apply_sign((uy > POS_LIMIT && !npy) ? POS_LIMIT : uy, npy);
    o.dbearing_dx = sat_term(py, 64'd1 << (2 * FRAC), r2, !npy);
    o.dbearing_dy = sat_term(px, 64'd1 << (2 * FRAC), r2, npx);
    a = vx * py;
    sa = nvx != npy;
    b = vy * px;
    sb = nvy != npx;
    if (sa != sb) begin
      cm = a + b;
      cneg = sa;
    end else if (a >= b) begin
      cm = a - b;
      cneg = sa;
    end else begin
      cm = b - a;
      cneg = !sa;
    end
    o.drate_dx = sat_term(cm, uy, r2, npy != cneg);
    o.drate_dy = sat_term(cm, ux, r2, !(npx != cneg));
    o.near_zero_error = 1'b0;
    return o;
  endfunction

  function automatic rmj_in_t track(input logic [31:0] px, input logic [31:0] py,
                                    input logic [31:0] vx, input logic [31:0] vy);
    rmj_in_t t;
    t.pos_x = px;
    t.pos_y = py;
    t.vel_x = vx;
    t.vel_y = vy;
    return t;
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] m;
    logic neg;
    neg = $urandom_range(0, 1);
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: m = $urandom_range(0, 1024);
      3: m = $urandom_range(0, 32'h00FF_FFFF);
      4: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: m = $urandom >> $urandom_range(0, 31);
    endcase
    return neg ? -m : m;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL radar_measurement_jacobian_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    rmj_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_jacobians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %h", out_data);
      end else begin
        want = pending_jacobians.pop_front();
        if (want.drange_dx !== out_data.drange_dx || want.drange_dy !== out_data.drange_dy ||
            want.dbearing_dx !== out_data.dbearing_dx ||
            want.dbearing_dy !== out_data.dbearing_dy ||
            want.drate_dx !== out_data.drate_dx || want.drate_dy !== out_data.drate_dy ||
            want.near_zero_error !== out_data.near_zero_error) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %h %h %h %h %h %h %b", want.drange_dx,
                     want.drange_dy, want.dbearing_dx, want.dbearing_dy, want.drate_dx,
                     want.drate_dy, want.near_zero_error);
            $display("          actual   %h %h %h %h %h %h %b", out_data.drange_dx,
                     out_data.drange_dy, out_data.dbearing_dx, out_data.dbearing_dy,
                     out_data.drate_dx, out_data.drate_dy, out_data.near_zero_error);
          end
        end
      end
    end
  end

  task automatic send_track(input rmj_in_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_jacobians.push_back(jacobian_of(t, range_floor));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_jacobians.size() != 0) @(negedge clk);
  endtask

  task automatic write_range_floor(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    range_floor = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_extremes();
    send_track(track(32'h0, 32'h0, 32'h0, 32'h0));
    send_track(track(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_track(track(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_track(track(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_track(track(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_track(track(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000));
    send_track(track(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001));
  endtask

  task automatic test_threshold_edges();
    send_track(track(32'd655, 32'd0, 32'd100, 32'd100));
    send_track(track(32'd656, 32'd0, 32'd100, 32'd100));
    write_range_floor(40'd430336);
    send_track(track(32'd656, 32'd0, 32'd100, 32'd5));
    write_range_floor(40'd430337);
    send_track(track(32'd0, -32'd656, 32'd100, 32'd5));
  endtask

  task automatic test_saturation();
    write_range_floor(40'd0);
    send_track(track(32'd0, 32'd0, 32'd7, 32'd7));
    send_track(track(32'd1, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_track(track(32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF));
    send_track(track(-32'd1, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_track(track(32'd0, -32'd1, 32'h7FFF_FFFF, 32'h8000_0000));
    send_track(track(32'd3, 32'd4, 32'h8000_0000, 32'h7FFF_FFFF));
    write_range_floor(40'hFF_FFFF_FFFF);
    send_track(track(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1));
    send_track(track(32'h0010_0000, 32'h0, 32'd1, 32'd1));
  endtask

  task automatic test_random(input int count, input logic [CFG_W-1:0] thr);
    write_range_floor(thr);
    repeat (count) send_track(track(random_value(), random_value(), random_value(),
                                    random_value()));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    range_floor = CFG_RESET;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_threshold_edges();
    test_saturation();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(215, CFG_RESET);
    send_idle_pct = 82;
    recv_stall_pct = 0;
    test_random(215, 40'd0);
    send_idle_pct = 0;
    recv_stall_pct = 82;
    test_random(210, {8'd0, 32'($urandom)});
    send_idle_pct = 34;
    recv_stall_pct = 34;
    test_random(210, {8'($urandom_range(0, 255)), 32'($urandom)});

    drain_results();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_jacobians.size() == 0) begin
      $display("PASS radar_measurement_jacobian_unit");
    end else begin
      $display("FAIL radar_measurement_jacobian_unit");
    end
    $finish;
  end
endmodule
